// ----- hdl/bankers_safety_allocator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the safety allocator
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BANKERS_SAFETY_ALLOCATOR_UNIT_MACROS_SVH
`define BANKERS_SAFETY_ALLOCATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define BSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define BSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Field widths, command and status codes, and shared types of the allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int MODE_W      = 2;
    localparam int SLOT_W      = 4;
    localparam int AMT_W       = 16;
    localparam int STATUS_W    = 3;
    localparam int CFG_W       = 16;
    localparam int RESET_TOTAL = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_REGISTER = 2'd0,
        MODE_REQUEST  = 2'd1,
        MODE_RELEASE  = 2'd2,
        MODE_UNUSED   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED      = 3'd0,
        ST_OVER_CLAIM   = 3'd1,
        ST_INSUFFICIENT = 3'd2,
        ST_UNSAFE       = 3'd3,
        ST_RELEASED     = 3'd4,
        ST_IGNORED      = 3'd5,
        ST_REGISTERED   = 3'd6,
        ST_INVALID      = 3'd7
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic done;
        logic safe;
    } t_chk_sts;

endpackage

// ----- hdl/bsa_cmd_if.sv -----
// ----------------------------------------------------------------------------
// bsa_cmd_if
// Command channel: valid/ready handshake with mode, slot and amount.
// ----------------------------------------------------------------------------
interface bsa_cmd_if
    import bsa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [AMT_W-1:0]  amount;

    modport source (output valid, output mode, output slot, output amount, input ready);
    modport sink   (input valid, input mode, input slot, input amount, output ready);
endinterface

// ----- hdl/bsa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bsa_rsp_if
// Response channel: valid/ready handshake with status, available and holding.
// ----------------------------------------------------------------------------
interface bsa_rsp_if
    import bsa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [AMT_W-1:0]    available_now;
    logic [AMT_W-1:0]    slot_holding;

    modport source (output valid, output status, output available_now, output slot_holding,
                    input ready);
    modport sink   (input valid, input status, input available_now, input slot_holding,
                    output ready);
endinterface

// ----- hdl/bsa_ram.sv -----
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bsa_check.sv -----
// ----------------------------------------------------------------------------
// bsa_check
// Safety sweep: one slot per cycle through a shared compare/add unit, repeated
// passes until every valid slot can finish or a pass makes no progress.
// ----------------------------------------------------------------------------
module bsa_check
    import bsa_pkg::*;
#(
    parameter int NUM_SLOTS  = 16,
    parameter int UNIT_WIDTH = 16,
    localparam int SLOT_IW   = $clog2(NUM_SLOTS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [UNIT_WIDTH-1:0] i_avail0,
    input  logic [SLOT_IW-1:0]    i_tgt_slot,
    input  logic [UNIT_WIDTH-1:0] i_tgt_amt,
    input  logic [NUM_SLOTS-1:0]  i_valid,
    input  logic [UNIT_WIDTH-1:0] i_claim,
    input  logic [UNIT_WIDTH-1:0] i_held,
    output logic [SLOT_IW-1:0]    o_raddr,
    output t_chk_sts              o_sts
);

    localparam int AW = UNIT_WIDTH + 1;
    localparam logic [SLOT_IW-1:0]   LAST = SLOT_IW'(NUM_SLOTS - 1);
    localparam logic [NUM_SLOTS-1:0] ONE  = {{(NUM_SLOTS-1){1'b0}}, 1'b1};

    logic                 r_busy;
    logic                 r_proc;
    logic                 r_fin;
    logic                 r_safe;
    logic [SLOT_IW-1:0]   r_idx;
    logic [SLOT_IW-1:0]   r_pidx;
    logic [AW-1:0]        r_avail;
    logic [NUM_SLOTS-1:0] r_done;
    logic                 r_progress;

    logic                 is_tgt;
    logic [AW-1:0]        avail_x;
    logic [AW-1:0]        need;
    logic                 take;
    logic [NUM_SLOTS-1:0] done_nx;
    logic                 progress_nx;
    logic                 pass_end;
    logic                 all_done;
    logic                 finish;

    // The target slot sees its tentative holding: fold the amount into avail
    assign is_tgt      = (r_pidx == i_tgt_slot);
    assign avail_x     = r_avail + (is_tgt ? AW'(i_tgt_amt) : '0);
    assign need        = AW'(i_claim) - AW'(i_held);
    assign take        = r_proc && i_valid[r_pidx] && !r_done[r_pidx] && (need <= avail_x);
    assign done_nx     = r_done | (take ? (ONE << r_pidx) : '0);
    assign progress_nx = r_progress | take;
    assign pass_end    = r_proc && (r_pidx == LAST);
    assign all_done    = ((i_valid & ~done_nx) == '0);
    assign finish      = r_busy && pass_end && (all_done || !progress_nx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_proc <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_fin <= finish;
            if (i_start) begin
                r_busy <= 1'b1;
                r_proc <= 1'b0;
            end else if (finish) begin
                // drop the read already issued for the next pass
                r_busy <= 1'b0;
                r_proc <= 1'b0;
            end else begin
                r_proc <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx      <= '0;
            r_avail    <= AW'(i_avail0);
            r_done     <= '0;
            r_progress <= 1'b0;
        end else if (r_busy) begin
            r_idx  <= (r_idx == LAST) ? '0 : r_idx + 1'b1;
            r_done <= done_nx;
            if (take) begin
                r_avail <= avail_x + AW'(i_held);
            end
            r_progress <= pass_end ? 1'b0 : progress_nx;
        end
        r_pidx <= r_idx;
        if (finish) begin
            r_safe <= all_done;
        end
    end

    assign o_raddr    = r_idx;
    assign o_sts.done = r_fin;
    assign o_sts.safe = r_safe;

endmodule

// ----- hdl/bankers_safety_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// bankers_safety_allocator_unit
// Deadlock-avoiding allocator of one resource type over a table of slots.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command beat (mode, slot, amount); o_rsp returns exactly
//   one response beat per command (status, available_now, slot_holding).
//   i_cfg_we/i_cfg_wdata load the total unit count; this reloads the available
//   count and clears every slot. Write it only while no command is in flight.
//   Commands are handled one at a time; i_cmd.ready is high only when the
//   sequencer is idle. Slot table lives in one RAM read a slot per cycle.
//   Sequencing: an out-of-range slot goes from IDLE straight to DONE; register,
//   release and denied requests pass through READ, EXEC and DONE; the
//   response is then loaded into the output register. A request that passes
//   the claim and availability tests runs the safety sweep in CHECK: passes
//   over all slots, at most as many as there are valid slots, then DONE.
//   The sweep rate is set by the single RAM read port and the shared
//   compare/add unit, one slot each cycle.
//   Reset: available = 16 units (saturated to UNIT_WIDTH), all slots invalid.
//   When o_rsp.ready is low the response beat holds in the output register and
//   the next command may already be accepted; its result waits behind it.
// ----------------------------------------------------------------------------
`include "bankers_safety_allocator_unit_macros.svh"

module bankers_safety_allocator_unit
    import bsa_pkg::*;
#(
    parameter int NUM_SLOTS  = 16,
    parameter int UNIT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    bsa_cmd_if.sink          i_cmd,
    bsa_rsp_if.source        o_rsp
);

    localparam int SLOT_IW = $clog2(NUM_SLOTS);
    localparam int U       = UNIT_WIDTH;
    localparam int SW      = (U > AMT_W) ? U : AMT_W;
    localparam int CW      = SW + 1;
    localparam logic [63:0]   UNIT_MAX64  = (64'd1 << U) - 64'd1;
    localparam logic [SW-1:0] UNIT_MAX_W  = SW'(UNIT_MAX64);
    localparam logic [U-1:0]  RESET_AVAIL = (64'(RESET_TOTAL) > UNIT_MAX64) ?
                                            {U{1'b1}} : U'(RESET_TOTAL);

    t_state               r_state, n_state;
    t_mode                r_mode;
    logic [SLOT_IW-1:0]   r_slot;
    logic [AMT_W-1:0]     r_amt;
    logic [U-1:0]         r_avail, n_avail;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [U-1:0]         r_claim, n_claim;
    logic [U-1:0]         r_held, n_held;
    t_status              r_res_status, n_res_status;
    logic [U-1:0]         r_res_hold, n_res_hold;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status;
    logic [AMT_W-1:0]     r_out_avail;
    logic [AMT_W-1:0]     r_out_hold;

    logic                 cmd_acc;
    logic                 in_range;
    logic                 out_load;
    logic                 slot_ok;
    logic [U-1:0]         rd_claim;
    logic [U-1:0]         rd_held;
    logic [U-1:0]         amt_u;
    logic [U-1:0]         amt_sat;
    logic [U-1:0]         cfg_sat;
    logic                 over_claim;
    logic                 short_units;
    logic                 rel_fit;
    logic [U-1:0]         add_b;
    logic [U:0]           add_sum;
    logic [U-1:0]         add_sat;
    logic [U-1:0]         avail_less;
    logic [U-1:0]         held_plus;

    logic                 ram_we;
    logic [2*U-1:0]       ram_wdata;
    logic [SLOT_IW-1:0]   ram_raddr;
    logic [2*U-1:0]       ram_rdata;

    logic                 chk_start;
    logic [SLOT_IW-1:0]   chk_raddr;
    t_chk_sts             chk_sts;

    assign cmd_acc  = i_cmd.valid && i_cmd.ready;
    assign in_range = (32'(i_cmd.slot) < 32'(NUM_SLOTS));
    assign slot_ok  = r_valid[r_slot];
    assign rd_claim = ram_rdata[2*U-1:U];
    assign rd_held  = ram_rdata[U-1:0];

    assign amt_u   = U'(r_amt);
    assign amt_sat = (SW'(r_amt) > UNIT_MAX_W) ? {U{1'b1}} : amt_u;
    assign cfg_sat = (SW'(i_cfg_wdata) > UNIT_MAX_W) ? {U{1'b1}} : U'(i_cfg_wdata);

    assign over_claim  = (CW'(r_amt) + CW'(rd_held)) > CW'(rd_claim);
    assign short_units = CW'(r_amt) > CW'(r_avail);
    assign rel_fit     = CW'(r_amt) <= CW'(rd_held);

    // Shared return adder: partial release adds the amount, else the holding
    assign add_b   = (r_mode == MODE_RELEASE && r_amt != '0) ? amt_u : rd_held;
    assign add_sum = {1'b0, r_avail} + {1'b0, add_b};
    assign add_sat = add_sum[U] ? {U{1'b1}} : add_sum[U-1:0];

    assign avail_less = r_avail - amt_u;
    assign held_plus  = r_held + amt_u;

    always_comb begin
        n_state      = r_state;
        n_avail      = r_avail;
        n_valid      = r_valid;
        n_claim      = r_claim;
        n_held       = r_held;
        n_res_status = r_res_status;
        n_res_hold   = r_res_hold;
        ram_we       = 1'b0;
        ram_wdata    = {rd_claim, rd_held};
        chk_start    = 1'b0;
        out_load     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    if (in_range) begin
                        n_state = S_READ;
                    end else begin
                        n_res_status = ST_INVALID;
                        n_res_hold   = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                n_claim = rd_claim;
                n_held  = rd_held;
                case (r_mode)
                    MODE_REGISTER: begin
                        if (slot_ok) begin
                            n_avail = add_sat;
                        end
                        n_valid[r_slot] = 1'b1;
                        ram_we          = 1'b1;
                        ram_wdata       = {amt_sat, {U{1'b0}}};
                        n_res_status    = ST_REGISTERED;
                        n_res_hold      = '0;
                    end
                    MODE_REQUEST: begin
                        n_res_hold = rd_held;
                        if (!slot_ok) begin
                            n_res_status = ST_INVALID;
                            n_res_hold   = '0;
                        end else if (over_claim) begin
                            n_res_status = ST_OVER_CLAIM;
                        end else if (short_units) begin
                            n_res_status = ST_INSUFFICIENT;
                        end else begin
                            chk_start = 1'b1;
                            n_state   = S_CHECK;
                        end
                    end
                    MODE_RELEASE: begin
                        if (!slot_ok) begin
                            n_res_status = ST_INVALID;
                            n_res_hold   = '0;
                        end else if (r_amt == '0) begin
                            n_avail      = add_sat;
                            ram_we       = 1'b1;
                            ram_wdata    = {rd_claim, {U{1'b0}}};
                            n_res_status = ST_RELEASED;
                            n_res_hold   = '0;
                        end else if (rel_fit) begin
                            n_avail      = add_sat;
                            ram_we       = 1'b1;
                            ram_wdata    = {rd_claim, rd_held - amt_u};
                            n_res_status = ST_RELEASED;
                            n_res_hold   = rd_held - amt_u;
                        end else begin
                            n_res_status = ST_IGNORED;
                            n_res_hold   = rd_held;
                        end
                    end
                    default: begin
                        // unused mode: ignore, report the current holding
                        n_res_status = ST_IGNORED;
                        n_res_hold   = slot_ok ? rd_held : '0;
                    end
                endcase
            end
            S_CHECK: begin
                if (chk_sts.done) begin
                    n_state = S_DONE;
                    if (chk_sts.safe) begin
                        n_avail      = avail_less;
                        ram_we       = 1'b1;
                        ram_wdata    = {r_claim, held_plus};
                        n_res_status = ST_GRANTED;
                        n_res_hold   = held_plus;
                    end else begin
                        n_res_status = ST_UNSAFE;
                        n_res_hold   = r_held;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_avail = cfg_sat;
            n_valid = '0;
        end
    end

    assign n_out_valid = out_load || (r_out_valid && !o_rsp.ready);
    assign ram_raddr   = (r_state == S_CHECK) ? chk_raddr : r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_avail     <= RESET_AVAIL;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_avail     <= n_avail;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_mode <= t_mode'(i_cmd.mode);
            r_slot <= SLOT_IW'(i_cmd.slot);
            r_amt  <= i_cmd.amount;
        end
        r_claim      <= n_claim;
        r_held       <= n_held;
        r_res_status <= n_res_status;
        r_res_hold   <= n_res_hold;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_avail  <= AMT_W'(r_avail);
            r_out_hold   <= AMT_W'(r_res_hold);
        end
    end

    bsa_ram #(
        .WIDTH (2 * U),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bsa_check #(
        .NUM_SLOTS  (NUM_SLOTS),
        .UNIT_WIDTH (UNIT_WIDTH)
    ) u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (chk_start),
        .i_avail0   (avail_less),
        .i_tgt_slot (r_slot),
        .i_tgt_amt  (amt_u),
        .i_valid    (r_valid),
        .i_claim    (rd_claim),
        .i_held     (rd_held),
        .o_raddr    (chk_raddr),
        .o_sts      (chk_sts)
    );

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.available_now = r_out_avail;
    assign o_rsp.slot_holding  = r_out_hold;

    `BSA_ASSERT_NXT(a_cmd_busy_after_accept, i_clk, i_rst_n, cmd_acc, !i_cmd.ready, "ready after accept")
    `BSA_ASSERT_IMP(a_chk_done_in_check, i_clk, i_rst_n, chk_sts.done, r_state == S_CHECK, "stray sweep done")
    `BSA_ASSERT_IMP(a_ram_write_state, i_clk, i_rst_n, ram_we, (r_state == S_EXEC) || (r_state == S_CHECK), "table write out of step")
    `BSA_ASSERT_IMP(a_invalid_no_holding, i_clk, i_rst_n, r_out_valid && (r_out_status == ST_INVALID), r_out_hold == '0, "invalid slot with holding")

endmodule
